[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[rtl/core/pme_pkg.sv]
// Package with types, constants and helpers of the charge spreading unit.
package pme_pkg;
  localparam int unsigned MaxGridDef = 32;
  localparam int unsigned SplineOrderDef = 5;
  localparam int unsigned GsW = 6;
  localparam int unsigned AccW = 48;
  localparam int unsigned WgtW = 25;
  localparam int unsigned QW = 24;
  localparam int unsigned FracW = 16;

  typedef enum logic [1:0] {
    OpSpread = 2'd0,
    OpClear  = 2'd1,
    OpRead   = 2'd2,
    OpNop    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    RegGridX = 2'd0,
    RegGridY = 2'd1,
    RegGridZ = 2'd2,
    RegNone  = 2'd3
  } reg_e;

  typedef enum logic [3:0] {
    StIdle, StClear, StReadA, StReadB, StAxis, StAxisW,
    StPair, StTriple, StScale, StRd, StWr
  } state_e;

  typedef struct packed {
    logic       go;
  } axis_ctl_t;

  // Saturating write value of the accumulator.
  function automatic logic signed [AccW-1:0] sat_add(logic signed [AccW-1:0] a,
                                                      logic signed [25:0] c);
    logic signed [AccW:0] s;
    s = {a[AccW-1], a} + {{(AccW-25){c[25]}}, c};
    if (s[AccW] != s[AccW-1]) begin
      return s[AccW] ? {1'b1, {(AccW-1){1'b0}}} : {1'b0, {(AccW-1){1'b1}}};
    end
    return s[AccW-1:0];
  endfunction

  // Clamp a written grid size into [5, max].
  function automatic logic [GsW-1:0] clamp_size(logic [GsW-1:0] v, logic [GsW-1:0] mx);
    if (v < GsW'(SplineOrderDef)) return GsW'(SplineOrderDef);
    if (v > mx) return mx;
    return v;
  endfunction
endpackage

[rtl/core/pme_charge_spread_bspline5_unit.sv]
// Top level of the order-5 B-spline charge spreading unit.
// Use: raise start with a command on the operation and payload ports; the
// beat is taken at the first rising edge at which busy is low. A spread beat
// keeps busy high through spline setup (each axis in turn on the multiplier
// of the axis unit), then for each of the 25 x-y knot pairs a pair weight
// step followed, for each of its five grid updates, by the states triple
// weight, charge scaling, memory read and saturating write. The pair and
// triple weights of the update loop share one multiplier. A clear beat
// sweeps the whole grid, one entry a cycle (MAX_GRID^3 = 32768 entries);
// reset does the same sweep before the first beat is taken, with busy high
// throughout. A read beat passes through its read states and puts its
// result on grid_value_o in the cycle in which it raises result_valid_o;
// the receiver cannot hold results, so it must sample that cycle. A
// no-operation beat is taken without raising busy. Configuration beats are
// taken at any time and saturate the grid size into [5, MAX_GRID].
module pme_charge_spread_bspline5_unit
  import pme_pkg::*;
#(
  parameter int unsigned SplineOrder = SplineOrderDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [1:0]           operation_i,
  input  logic [FracW-1:0]     frac_x_i,
  input  logic [FracW-1:0]     frac_y_i,
  input  logic [FracW-1:0]     frac_z_i,
  input  logic signed [QW-1:0] atom_charge_i,
  input  logic [14:0]          read_index_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [1:0]           cfg_index_i,
  input  logic [GsW-1:0]       cfg_data_i,
  output logic                 result_valid_o,
  output logic signed [AccW-1:0] grid_value_o
);
  `include "assert_macros.svh"

  localparam int unsigned MaxGrid = MaxGridDef;
  localparam int unsigned Depth = MaxGrid * MaxGrid * MaxGrid;
  localparam int unsigned AW = $clog2(Depth);
  localparam logic [GsW-1:0] MaxG = GsW'(MaxGrid);

  logic [GsW-1:0] nx_q, ny_q, nz_q;
  state_e state_q, state_d;
  logic signed [AccW-1:0] mem [Depth];
  logic signed [AccW-1:0] rd_q;
  logic [AW-1:0] addr_q, addr_d;
  logic [AW:0]   clr_q, clr_d;
  logic [14:0]   ridx_q;
  logic          rok_q;
  logic [1:0]    ax_q, ax_d;
  logic [2:0]    i_q, i_d, j_q, j_d, k_q, k_d;
  logic [GsW-1:0] fl [3];
  logic [WgtW-1:0] wt [3][SplineOrder];
  logic [WgtW-1:0] ax_w [SplineOrder];
  logic [GsW-1:0] ax_fl;
  logic ax_done;
  axis_ctl_t ax_ctl;
  logic [FracW-1:0] fx_q, fy_q, fz_q;
  logic signed [QW-1:0] q_q;
  logic [WgtW:0] wxy_q, wxyz_q;
  logic signed [25:0] c_q;
  logic [GsW-1:0] kx, ky, kz;
  logic [20:0] lin;
  logic [49:0] wprod;
  logic signed [49:0] qprod;
  logic mem_we;
  logic signed [AccW-1:0] mem_wd;
  logic [AW-1:0] mem_wa;

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nx_q <= MaxG; ny_q <= MaxG; nz_q <= MaxG;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegGridX: nx_q <= clamp_size(cfg_data_i, MaxG);
        RegGridY: ny_q <= clamp_size(cfg_data_i, MaxG);
        RegGridZ: nz_q <= clamp_size(cfg_data_i, MaxG);
        default: ;
      endcase
    end
  end

  assign ax_ctl.go = (state_q == StAxis);

  pme_axis #(.SplineOrder(SplineOrder)) u_axis (
    .clk_i, .rst_ni, .ctl_i(ax_ctl),
    .frac_i(ax_q == 2'd0 ? fx_q : (ax_q == 2'd1 ? fy_q : fz_q)),
    .size_i(ax_q == 2'd0 ? nx_q : (ax_q == 2'd1 ? ny_q : nz_q)),
    .done_o(ax_done), .floor_o(ax_fl), .w_o(ax_w)
  );

  function automatic logic [GsW-1:0] knot(logic [GsW-1:0] g, logic [2:0] i,
                                         logic [GsW-1:0] n);
    logic signed [GsW+1:0] v;
    v = $signed({2'b0, g}) + $signed({5'b0, i}) - 8'sd4;
    if (v < 0) v = v + $signed({2'b0, n});
    return v[GsW-1:0];
  endfunction

  assign kx = knot(fl[0], i_q, nx_q);
  assign ky = knot(fl[1], j_q, ny_q);
  assign kz = knot(fl[2], k_q, nz_q);
  assign lin = (21'(kx) * 21'(ny_q) + 21'(ky)) * 21'(nz_q) + 21'(kz);

  // The shared weight multiplier of the update loop, and the charge multiplier.
  always_comb begin
    if (state_q == StPair) wprod = 50'(wt[0][i_q]) * 50'(wt[1][j_q]);
    else wprod = 50'(wxy_q) * 50'(wt[2][k_q]);
    qprod = $signed({{26{q_q[QW-1]}}, q_q}) * $signed({24'b0, wxyz_q});
  end

  always_comb begin
    state_d = state_q; addr_d = addr_q; clr_d = clr_q; ax_d = ax_q;
    i_d = i_q; j_d = j_q; k_d = k_q;
    mem_we = 1'b0; mem_wa = addr_q; mem_wd = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          case (operation_i)
            OpSpread: begin state_d = StAxis; ax_d = 2'd0; end
            OpClear:  begin state_d = StClear; clr_d = '0; end
            OpRead:   state_d = StReadA;
            default:  ;
          endcase
        end
      end
      StClear: begin
        mem_we = 1'b1; mem_wa = clr_q[AW-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q == (AW+1)'(Depth - 1)) state_d = StIdle;
      end
      StReadA: state_d = StReadB;
      StReadB: state_d = StIdle;
      StAxis: state_d = StAxisW;
      StAxisW: if (ax_done) begin
        if (ax_q == 2'd2) begin
          state_d = StPair; i_d = '0; j_d = '0; k_d = '0;
        end else begin
          ax_d = ax_q + 2'd1; state_d = StAxis;
        end
      end
      StPair: state_d = StTriple;
      StTriple: state_d = StScale;
      StScale: begin state_d = StRd; addr_d = AW'(lin); end
      StRd: state_d = (lin < 21'(Depth)) ? StWr : StWr;
      StWr: begin
        mem_we = (lin < 21'(Depth));
        mem_wa = addr_q; mem_wd = sat_add(rd_q, c_q);
        if (k_q != 3'd4) begin k_d = k_q + 1'b1; state_d = StTriple; end
        else begin
          k_d = '0;
          if (j_q != 3'd4) begin j_d = j_q + 1'b1; state_d = StPair; end
          else begin
            j_d = '0;
            if (i_q != 3'd4) begin i_d = i_q + 1'b1; state_d = StPair; end
            else state_d = StIdle;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClear; clr_q <= '0; addr_q <= '0; ax_q <= '0;
      i_q <= '0; j_q <= '0; k_q <= '0; result_valid_o <= 1'b0;
    end else begin
      state_q <= state_d; clr_q <= clr_d; addr_q <= addr_d; ax_q <= ax_d;
      i_q <= i_d; j_q <= j_d; k_q <= k_d;
      result_valid_o <= (state_q == StReadB);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start) begin
      fx_q <= frac_x_i; fy_q <= frac_y_i; fz_q <= frac_z_i;
      q_q <= atom_charge_i; ridx_q <= read_index_i;
    end
    if (state_q == StReadA)
      rok_q <= (21'(ridx_q) < 21'(nx_q) * 21'(ny_q) * 21'(nz_q))
               && (16'(ridx_q) < 16'(Depth));
    if (state_q == StAxisW && ax_done) begin
      fl[ax_q] <= ax_fl;
      wt[ax_q] <= ax_w;
    end
    if (state_q == StPair) wxy_q <= (WgtW+1)'((wprod + 50'(1 << 22)) >> 23);
    if (state_q == StTriple) wxyz_q <= (WgtW+1)'((wprod + 50'(1 << 22)) >> 23);
    if (state_q == StScale) c_q <= 26'((qprod + 50'sd4194304) >>> 23);
    if (state_q == StReadB) grid_value_o <= rok_q ? rd_q : '0;
  end

  // Grid memory: one write and one registered read a cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rd_q <= mem[(state_q == StReadA) ? AW'(ridx_q) : addr_q];
  end

  assign busy = (state_q != StIdle);

  `ASSERT_NEXT(a_read_result, clk_i, rst_ni, state_q == StReadB, result_valid_o)
  `ASSERT_IMPL(a_valid_only_read, clk_i, rst_ni, result_valid_o, state_q != StReadB)
  `ASSERT_IMPL(a_idx_range, clk_i, rst_ni, state_q == StWr, i_q < 3'd5 && k_q < 3'd5)
endmodule

[rtl/core/pme_axis.sv]
// Per-axis spline weight unit: one shared multiplier stepped through a sequence of products.
module pme_axis
  import pme_pkg::*;
#(
  parameter int unsigned SplineOrder = SplineOrderDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  axis_ctl_t          ctl_i,
  input  logic [FracW-1:0]   frac_i,
  input  logic [GsW-1:0]     size_i,
  output logic               done_o,
  output logic [GsW-1:0]     floor_o,
  output logic [WgtW-1:0]    w_o [SplineOrder]
);
  // Sequence: p=frac*n, T2=T*T, T3=T2*T, T4=T3*T, then weight evaluation.
  logic [2:0]  step_q, step_d;
  logic        busy_q, busy_d;
  logic [21:0] p_q;
  logic [31:0] t2_q;
  logic [47:0] t3_q;
  logic [47:0] a4_q;
  logic [47:0] ma;
  logic [15:0] mb;
  logic [63:0] mp;
  logic [15:0] t;
  logic signed [55:0] a1, a2, a3, a4, one;
  logic signed [55:0] n [5];

  // Numerator over 24*2^25 with half-up rounding, never negative. The divisor
  // is 3*2^28: the low 28 bits are dropped and the rest is multiplied by the
  // reciprocal of three, which is exact for any dividend below 2^32.
  function automatic logic [WgtW-1:0] round_div24(logic signed [55:0] num);
    logic [55:0] x;
    logic [25:0] y;
    logic [63:0] prod;
    if (num < 0) return '0;
    x = num + (56'sd12 <<< 25);
    y = x[53:28];
    prod = 64'(y) * 64'(32'hAAAA_AAAB);
    return prod[33+WgtW-1:33];
  endfunction

  assign t  = p_q[15:0];
  assign mp = ma * mb;

  always_comb begin
    ma = '0;
    mb = '0;
    case (step_q)
      3'd0: begin ma = 48'(frac_i); mb = 16'(size_i); end
      3'd1: begin ma = 48'(t); mb = t; end
      3'd2: begin ma = 48'(t2_q); mb = t; end
      3'd3: begin ma = t3_q; mb = t; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  always_comb begin
    step_d = step_q;
    busy_d = busy_q;
    if (ctl_i.go) begin
      busy_d = 1'b1;
      step_d = 3'd0;
    end else if (busy_q) begin
      if (step_q == 3'd4) busy_d = 1'b0;
      else step_d = step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      busy_q <= 1'b0;
    end else begin
      step_q <= step_d;
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (busy_q) begin
      case (step_q)
        3'd0: p_q <= mp[21:0];
        3'd1: t2_q <= mp[31:0];
        3'd2: t3_q <= mp[47:0];
        3'd3: a4_q <= mp[63:16];
        default: ;
      endcase
    end
  end

  assign done_o  = busy_q && (step_q == 3'd4);
  assign floor_o = p_q[21:16];

  always_comb begin
    one = 56'sd1 <<< 48;
    a1 = 56'(t) <<< 32;
    a2 = 56'(t2_q) <<< 16;
    a3 = 56'(t3_q);
    a4 = 56'(a4_q);
    n[0] = a4;
    n[1] = one + 4*a1 + 6*a2 + 4*a3 - 4*a4;
    n[2] = 11*one + 12*a1 - 6*a2 - 12*a3 + 6*a4;
    n[3] = 11*one - 12*a1 - 6*a2 + 12*a3 - 4*a4;
    n[4] = one - 4*a1 + 6*a2 - 4*a3 + a4;
    for (int i = 0; i < SplineOrder; i++) begin
      w_o[i] = round_div24(n[SplineOrder-1-i]);
    end
  end
endmodule
